// ----- hdl/sorted_key_table_top_macros.svh -----
// Assertion macros shared by the sorted key table RTL.
// Each macro expects aclk and aresetn to exist in the module that uses it.
`ifndef SORTED_KEY_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_TOP_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SKT_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/skt_pkg.sv -----
`timescale 1ns / 1ps
package skt_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int OP_W        = 2;
    localparam int KEY_W       = 32;
    localparam int IN_HANDLE_W = 16;
    localparam int STATUS_W    = 2;
    localparam int RANK_W      = 6;
    localparam int ECNT_W      = 7;

    // Input tdata layout.
    localparam int OP_LSB     = 0;
    localparam int KEY_LSB    = OP_LSB + OP_W;
    localparam int HANDLE_LSB = KEY_LSB + KEY_W;
    localparam int S_TDATA_W  = 56;

    // Output tdata layout.
    localparam int STATUS_LSB = 0;
    localparam int FH_LSB     = STATUS_LSB + STATUS_W;
    localparam int RANK_LSB   = FH_LSB + IN_HANDLE_W;
    localparam int ECNT_LSB   = RANK_LSB + RANK_W;
    localparam int M_TDATA_W  = 32;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_DUP       = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } state_t;

    // Broadcast from the controller to every cell in the apply cycle.
    typedef struct packed {
        logic ins_en;
        logic del_en;
    } commit_t;

endpackage

// ----- hdl/sorted_key_table_top.sv -----
`timescale 1ns / 1ps
// Sorted key table: up to CAPACITY entries of a signed 32-bit key and a record
// handle, held in ascending key order in a chain of cells.
// Input stream (s_): one operation per transaction; insert, delete or lookup.
// Output stream (m_): exactly one result transaction per accepted operation,
// in order, carrying status, found handle, rank and the entry count after the
// operation.
// Timing: an operation is taken in the idle state, then a scan wave runs down the
// chain one cell per cycle to gather the rank, the match and its handle, and
// an apply step applies the shift and registers the result. The next
// operation is taken the cycle after the result is registered; the scan
// runs over every cell of the chain, so the chain length sets its length.
// The result sits in an output register; a new operation is accepted while
// it waits, but that operation holds in its apply step until the receiver
// takes the earlier result, so a stalled receiver holds back at most one.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// result; key storage itself is not cleared.
module sorted_key_table_top
    import skt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // op[1:0], key[33:2], record_handle[49:34], zero [55:50]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], found_handle[17:2], rank[23:18], entry_count[30:24], zero [31]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int HW    = (HANDLE_BITS < IN_HANDLE_W) ? HANDLE_BITS : IN_HANDLE_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [KEY_W-1:0] cmd_key;
    logic [HW-1:0]           cmd_handle;
    logic [CNT_W-1:0]        count;
    commit_t                 commit;

    logic                    lt_c     [CAPACITY];
    logic signed [KEY_W-1:0] key_c    [CAPACITY];
    logic [HW-1:0]           handle_c [CAPACITY];
    logic [CNT_W-1:0]        rank_w   [CAPACITY+1];
    logic                    hit_w    [CAPACITY+1];
    logic [HW-1:0]           fh_w     [CAPACITY+1];

    assign rank_w[0] = '0;
    assign hit_w[0]  = 1'b0;
    assign fh_w[0]   = '0;

    skt_ctrl #(
        .CAPACITY (CAPACITY),
        .HW       (HW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cmd_key    (cmd_key),
        .cmd_handle (cmd_handle),
        .count      (count),
        .commit     (commit),
        .scan_rank  (rank_w[CAPACITY]),
        .scan_hit   (hit_w[CAPACITY]),
        .scan_fh    (fh_w[CAPACITY])
    );

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_chain
        logic                    left_lt;
        logic signed [KEY_W-1:0] left_key;
        logic [HW-1:0]           left_handle;
        logic signed [KEY_W-1:0] right_key;
        logic [HW-1:0]           right_handle;

        // The head cell sees an always-smaller neighbor; the tail keeps itself.
        if (gi == 0) begin : g_head
            assign left_lt     = 1'b1;
            assign left_key    = cmd_key;
            assign left_handle = cmd_handle;
        end else begin : g_mid_l
            assign left_lt     = lt_c[gi-1];
            assign left_key    = key_c[gi-1];
            assign left_handle = handle_c[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign right_key    = key_c[gi];
            assign right_handle = handle_c[gi];
        end else begin : g_mid_r
            assign right_key    = key_c[gi+1];
            assign right_handle = handle_c[gi+1];
        end

        skt_cell #(
            .INDEX    (gi),
            .CAPACITY (CAPACITY),
            .HW       (HW)
        ) u_cell (
            .aclk         (aclk),
            .cmd_key      (cmd_key),
            .cmd_handle   (cmd_handle),
            .count        (count),
            .commit       (commit),
            .left_lt      (left_lt),
            .left_key     (left_key),
            .left_handle  (left_handle),
            .right_key    (right_key),
            .right_handle (right_handle),
            .rank_in      (rank_w[gi]),
            .hit_in       (hit_w[gi]),
            .fh_in        (fh_w[gi]),
            .lt           (lt_c[gi]),
            .key          (key_c[gi]),
            .handle       (handle_c[gi]),
            .rank_out     (rank_w[gi+1]),
            .hit_out      (hit_w[gi+1]),
            .fh_out       (fh_w[gi+1])
        );
    end

endmodule

// ----- hdl/skt_cell.sv -----
`timescale 1ns / 1ps
module skt_cell
    import skt_pkg::*;
#(
    parameter int INDEX    = 0,
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int HW       = IN_HANDLE_W,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                    aclk,
    input  logic signed [KEY_W-1:0] cmd_key,
    input  logic [HW-1:0]           cmd_handle,
    input  logic [CNT_W-1:0]        count,
    input  commit_t                 commit,
    input  logic                    left_lt,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic [HW-1:0]           left_handle,
    input  logic signed [KEY_W-1:0] right_key,
    input  logic [HW-1:0]           right_handle,
    input  logic [CNT_W-1:0]        rank_in,
    input  logic                    hit_in,
    input  logic [HW-1:0]           fh_in,
    output logic                    lt,
    output logic signed [KEY_W-1:0] key,
    output logic [HW-1:0]           handle,
    output logic [CNT_W-1:0]        rank_out,
    output logic                    hit_out,
    output logic [HW-1:0]           fh_out
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic signed [KEY_W-1:0] key_reg;
    logic [HW-1:0]           handle_reg;
    logic [CNT_W-1:0]        rank_reg;
    logic                    hit_reg;
    logic [HW-1:0]           fh_reg;
    logic                    valid;
    logic                    eq;

    assign valid = IDX < count;
    assign lt    = valid && (key_reg < cmd_key);
    assign eq    = valid && (key_reg == cmd_key);

    // Entries below the insert/delete point stay; the rest shift by one place.
    always_ff @(posedge aclk) begin
        if (commit.ins_en && !lt) begin
            if (left_lt) begin
                key_reg    <= cmd_key;
                handle_reg <= cmd_handle;
            end else begin
                key_reg    <= left_key;
                handle_reg <= left_handle;
            end
        end else if (commit.del_en && !lt) begin
            key_reg    <= right_key;
            handle_reg <= right_handle;
        end
    end

    // The scan wave moves one cell further every cycle.
    always_ff @(posedge aclk) begin
        rank_reg <= rank_in + {{(CNT_W-1){1'b0}}, lt};
        hit_reg  <= hit_in | eq;
        fh_reg   <= eq ? handle_reg : fh_in;
    end

    assign key      = key_reg;
    assign handle   = handle_reg;
    assign rank_out = rank_reg;
    assign hit_out  = hit_reg;
    assign fh_out   = fh_reg;

endmodule

// ----- hdl/skt_ctrl.sv -----
`timescale 1ns / 1ps
`include "sorted_key_table_top_macros.svh"
module skt_ctrl
    import skt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int HW       = IN_HANDLE_W,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,
    output logic signed [KEY_W-1:0] cmd_key,
    output logic [HW-1:0]           cmd_handle,
    output logic [CNT_W-1:0]        count,
    output commit_t                 commit,
    input  logic [CNT_W-1:0]        scan_rank,
    input  logic                    scan_hit,
    input  logic [HW-1:0]           scan_fh
);

    localparam int SC_W = $clog2(CAPACITY);

    state_t                  state_reg, state_next;
    logic [SC_W-1:0]         scan_cnt_reg, scan_cnt_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [HW-1:0]           handle_reg, handle_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]    out_data_reg, out_data_next;

    logic [STATUS_W-1:0]     res_status;
    logic [HW-1:0]           res_fh;
    logic [CNT_W-1:0]        res_rank;
    logic [CNT_W-1:0]        res_count;
    commit_t                 res_commit;
    logic                    full;
    logic [HW+IN_HANDLE_W-1:0] fh_ext;
    logic [CNT_W+RANK_W-1:0] rank_ext;
    logic [CNT_W+ECNT_W-1:0] count_ext;

    assign full = count_reg == CNT_W'(CAPACITY);

    // Outcome of the operation once the scan wave has left the last cell.
    always_comb begin
        res_status = STS_OK;
        res_fh     = '0;
        res_rank   = '0;
        res_count  = count_reg;
        res_commit = '0;
        case (op_reg)
            OP_INSERT: begin
                if (scan_hit) begin
                    res_status = STS_DUP;
                    res_rank   = scan_rank;
                end else if (full) begin
                    res_status = STS_FULL;
                end else begin
                    res_rank          = scan_rank;
                    res_count         = count_reg + 1'b1;
                    res_commit.ins_en = 1'b1;
                end
            end
            OP_DELETE: begin
                if (!scan_hit) begin
                    res_status = STS_NOT_FOUND;
                end else begin
                    res_rank          = scan_rank;
                    res_count         = count_reg - 1'b1;
                    res_commit.del_en = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (!scan_hit) begin
                    res_status = STS_NOT_FOUND;
                end else begin
                    res_rank = scan_rank;
                    res_fh   = scan_fh;
                end
            end
            default: begin
            end
        endcase
    end

    assign fh_ext    = {{IN_HANDLE_W{1'b0}}, res_fh};
    assign rank_ext  = {{RANK_W{1'b0}}, res_rank};
    assign count_ext = {{ECNT_W{1'b0}}, res_count};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_cnt_reg <= scan_cnt_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        handle_reg   <= handle_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        handle_next    = handle_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        commit         = '0;
        s_tready       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next       = s_tdata[OP_LSB +: OP_W];
                    key_next      = s_tdata[KEY_LSB +: KEY_W];
                    handle_next   = s_tdata[HANDLE_LSB +: HW];
                    scan_cnt_next = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SC_W'(CAPACITY - 1)) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                // The table changes only in the cycle the result is registered.
                if (!out_valid_reg || m_tready) begin
                    commit         = res_commit;
                    count_next     = res_count;
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, count_ext[ECNT_W-1:0], rank_ext[RANK_W-1:0],
                                      fh_ext[IN_HANDLE_W-1:0], res_status};
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign cmd_key    = key_reg;
    assign cmd_handle = handle_reg;
    assign count      = count_reg;

    `SKT_ASSERT(a_count_in_range, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `SKT_ASSERT(a_commit_exclusive, !(commit.ins_en && commit.del_en), "insert and delete at once")
    `SKT_ASSERT_NEXT(a_ins_grows, commit.ins_en, count_reg == $past(count_reg) + 1'b1, "insert count")
    `SKT_ASSERT_NEXT(a_commit_gives_result, commit.ins_en || commit.del_en, m_tvalid, "lost result")

endmodule

// ----- sim/tb_sorted_key_table_top.sv -----
`timescale 1ns / 1ps
module tb_sorted_key_table_top;
    import skt_pkg::*;

    localparam int TBL_CAP  = CAPACITY_DEF;
    localparam int POOL_N   = 16;
    localparam int N_RANDOM = 700;
    localparam int TAIL_CYC = 2 * (TBL_CAP + 2);

    // The one op code that the block treats as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [IN_HANDLE_W-1:0] found_handle;
        logic [RANK_W-1:0]      rank;
        logic [ECNT_W-1:0]      entry_count;
    } table_result_t;

    typedef struct {
        logic [OP_W-1:0]        op;
        logic [KEY_W-1:0]       key;
        logic [IN_HANDLE_W-1:0] hnd;
        bit                     drain_first;
    } table_op_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    sorted_key_table_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the table, advanced once per accepted operation.
    logic signed [KEY_W-1:0]   tbl_keys    [TBL_CAP];
    logic [IN_HANDLE_W-1:0]    tbl_handles [TBL_CAP];
    int                        tbl_count = 0;

    table_op_t     pending_ops [$];
    table_result_t result_q    [$];
    int            err_count = 0;

    // Stimulus-side view of the keys believed present; it only steers the mix.
    logic [KEY_W-1:0] live_keys [$];
    logic [KEY_W-1:0] key_pool  [POOL_N];
    int               items_added = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic table_result_t apply_table_op(logic [OP_W-1:0] op,
                                                     logic signed [KEY_W-1:0] key,
                                                     logic [IN_HANDLE_W-1:0] hnd);
        table_result_t r;
        int            pos;
        int            j;
        bit            hit;
        r   = '0;
        pos = 0;
        while (pos < tbl_count && tbl_keys[pos] < key) pos++;
        hit = (pos < tbl_count) && (tbl_keys[pos] == key);
        case (op)
            OP_INSERT: begin
                if (hit) begin
                    r.status = STS_DUP;
                    r.rank   = pos[RANK_W-1:0];
                end else if (tbl_count >= TBL_CAP) begin
                    r.status = STS_FULL;
                end else begin
                    for (j = tbl_count; j > pos; j--) begin
                        tbl_keys[j]    = tbl_keys[j-1];
                        tbl_handles[j] = tbl_handles[j-1];
                    end
                    tbl_keys[pos]    = key;
                    tbl_handles[pos] = hnd;
                    tbl_count++;
                    r.status = STS_OK;
                    r.rank   = pos[RANK_W-1:0];
                end
            end
            OP_DELETE: begin
                if (!hit) begin
                    r.status = STS_NOT_FOUND;
                end else begin
                    for (j = pos; j < tbl_count - 1; j++) begin
                        tbl_keys[j]    = tbl_keys[j+1];
                        tbl_handles[j] = tbl_handles[j+1];
                    end
                    tbl_count--;
                    r.status = STS_OK;
                    r.rank   = pos[RANK_W-1:0];
                end
            end
            OP_LOOKUP: begin
                if (!hit) begin
                    r.status = STS_NOT_FOUND;
                end else begin
                    r.status       = STS_OK;
                    r.found_handle = tbl_handles[pos];
                    r.rank         = pos[RANK_W-1:0];
                end
            end
            default: ;
        endcase
        r.entry_count = tbl_count[ECNT_W-1:0];
        return r;
    endfunction

    task automatic add_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                          input logic [IN_HANDLE_W-1:0] hnd, input bit drain_first);
        table_op_t t;
        t.op          = op;
        t.key         = key;
        t.hnd         = hnd;
        t.drain_first = drain_first;
        pending_ops.push_back(t);
        items_added++;
    endtask

    task automatic note_insert(input logic [KEY_W-1:0] key);
        int found[$];
        found = live_keys.find_first_index(x) with (x == key);
        if (found.size() == 0 && live_keys.size() < TBL_CAP) live_keys.push_back(key);
    endtask

    task automatic note_delete(input logic [KEY_W-1:0] key);
        int found[$];
        found = live_keys.find_first_index(x) with (x == key);
        if (found.size() != 0) live_keys.delete(found[0]);
    endtask

    // Sender: bursts of transactions separated by random gaps.
    int gap_left   = 0;
    int burst_left = 1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                result_q.push_back(apply_table_op(s_tdata[OP_LSB +: OP_W],
                                                  s_tdata[KEY_LSB +: KEY_W],
                                                  s_tdata[HANDLE_LSB +: IN_HANDLE_W]));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0 &&
                             !(pending_ops[0].drain_first && result_q.size() > 0)) begin
                    s_tdata  <= {{(S_TDATA_W - OP_W - KEY_W - IN_HANDLE_W){1'b0}},
                                 pending_ops[0].hnd, pending_ops[0].key, pending_ops[0].op};
                    s_tvalid <= 1'b1;
                    pending_ops.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 120)
                                                                  : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: segments of steady ready, ready then stall, or per-cycle coin flips.
    int rdy_mode = 0;
    int rdy_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rdy_left <= 0;
        end else if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(0, 2);
            rdy_left <= $urandom_range(1, 300);
            m_tready <= 1'($urandom_range(0, 1));
        end else begin
            rdy_left <= rdy_left - 1;
            case (rdy_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= (rdy_left > 150) ? 1'b1 : 1'b0;
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // Result checker.
    always @(posedge aclk) begin : result_check
        table_result_t want;
        table_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status       = m_tdata[STATUS_LSB +: STATUS_W];
            got.found_handle = m_tdata[FH_LSB +: IN_HANDLE_W];
            got.rank         = m_tdata[RANK_LSB +: RANK_W];
            got.entry_count  = m_tdata[ECNT_LSB +: ECNT_W];
            if (result_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("ERROR: unexpected result transaction %h", m_tdata);
            end else begin
                want = result_q.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"ERROR: status exp %0d got %0d, handle exp %h got %h, ",
                                  "rank exp %0d got %0d, count exp %0d got %0d"},
                                 want.status, got.status, want.found_handle,
                                 got.found_handle, want.rank, got.rank,
                                 want.entry_count, got.entry_count);
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("sorted_key_table_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        int               i;
        int               n;
        int               r;
        int               idx;
        int               phase;
        int               base;
        logic [KEY_W-1:0] k;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        for (i = 5; i < POOL_N; i++) key_pool[i] = $urandom_range(0, 40) - 20;

        // Empty table, extreme keys, duplicate, head and tail removal, unused op.
        add_op(OP_LOOKUP, 32'd5,          16'h0000, 1'b0);
        add_op(OP_DELETE, 32'd5,          16'h0000, 1'b0);
        add_op(OP_UNUSED, 32'hFFFF_FFFF,  16'hFFFF, 1'b0);
        add_op(OP_INSERT, 32'h0000_0000,  16'hFFFF, 1'b0);
        add_op(OP_INSERT, 32'h8000_0000,  16'h0000, 1'b0);
        add_op(OP_INSERT, 32'h7FFF_FFFF,  16'hAAAA, 1'b0);
        add_op(OP_INSERT, 32'hFFFF_FFFF,  16'h5555, 1'b0);
        add_op(OP_INSERT, 32'h0000_0001,  16'h0001, 1'b0);
        add_op(OP_INSERT, 32'h0000_0000,  16'h1234, 1'b0);
        add_op(OP_LOOKUP, 32'h8000_0000,  16'h0000, 1'b0);
        add_op(OP_LOOKUP, 32'h7FFF_FFFF,  16'h0000, 1'b0);
        add_op(OP_LOOKUP, 32'hFFFF_FFFF,  16'h0000, 1'b0);
        add_op(OP_LOOKUP, 32'h0000_0000,  16'hFFFF, 1'b0);
        add_op(OP_LOOKUP, 32'h0000_0002,  16'h0000, 1'b0);
        add_op(OP_DELETE, 32'h8000_0000,  16'h0000, 1'b0);
        add_op(OP_DELETE, 32'h7FFF_FFFF,  16'h0000, 1'b0);
        add_op(OP_DELETE, 32'h0000_0007,  16'h0000, 1'b0);
        add_op(OP_UNUSED, 32'h8000_0000,  16'h0000, 1'b0);
        add_op(OP_INSERT, 32'h8000_0000,  16'hFFFF, 1'b0);
        add_op(OP_LOOKUP, 32'h8000_0000,  16'h0000, 1'b0);
        live_keys.push_back(32'h0000_0000);
        live_keys.push_back(32'hFFFF_FFFF);
        live_keys.push_back(32'h0000_0001);
        live_keys.push_back(32'h8000_0000);

        base = items_added;
        while (items_added - base < N_RANDOM) begin
            if (live_keys.size() > 40) phase = ($urandom_range(0, 2) == 0) ? 1 : 2;
            else phase = ($urandom_range(0, 2) == 0) ? 1 : 0;
            case (phase)
                0: begin
                    // Fill past capacity with mostly fresh keys.
                    n = TBL_CAP + $urandom_range(4, 14);
                    for (i = 0; i < n; i++) begin
                        r = $urandom_range(0, 9);
                        if (r == 0 && live_keys.size() > 0) begin
                            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                            add_op(OP_INSERT, k, IN_HANDLE_W'($urandom), i == 0);
                        end else if (r == 1 && live_keys.size() > 0) begin
                            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                            add_op(OP_LOOKUP, k, IN_HANDLE_W'($urandom), i == 0);
                        end else begin
                            k = (r < 4) ? $urandom_range(0, 400) - 200 : $urandom;
                            add_op(OP_INSERT, k, IN_HANDLE_W'($urandom), i == 0);
                            note_insert(k);
                        end
                    end
                end
                1: begin
                    n = 40;
                    for (i = 0; i < n; i++) begin
                        r = $urandom_range(0, 9);
                        idx = $urandom_range(0, 9);
                        if (idx < 5) k = key_pool[$urandom_range(0, POOL_N - 1)];
                        else if (idx < 8 && live_keys.size() > 0)
                            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                        else k = $urandom;
                        if (r < 4) begin
                            add_op(OP_INSERT, k, IN_HANDLE_W'($urandom), i == 0);
                            note_insert(k);
                        end else if (r < 6) begin
                            add_op(OP_DELETE, k, IN_HANDLE_W'($urandom), i == 0);
                            note_delete(k);
                        end else if (r < 9) begin
                            add_op(OP_LOOKUP, k, IN_HANDLE_W'($urandom), i == 0);
                        end else begin
                            add_op(OP_UNUSED, k, IN_HANDLE_W'($urandom), i == 0);
                        end
                    end
                end
                default: begin
                    // Empty the table in random order, with lookups and misses mixed in.
                    i = 0;
                    while (live_keys.size() > 0) begin
                        idx = $urandom_range(0, live_keys.size() - 1);
                        k = live_keys[idx];
                        r = $urandom_range(0, 5);
                        if (r == 0) begin
                            add_op(OP_DELETE, $urandom, IN_HANDLE_W'($urandom), i == 0);
                        end else if (r == 1) begin
                            add_op(OP_LOOKUP, k, IN_HANDLE_W'($urandom), i == 0);
                        end else begin
                            add_op(OP_DELETE, k, IN_HANDLE_W'($urandom), i == 0);
                            live_keys.delete(idx);
                        end
                        i++;
                    end
                end
            endcase
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid) @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYC) @(posedge aclk);

        if (err_count == 0 && result_q.size() == 0) begin
            $display("sorted_key_table_top regression: pass");
        end else begin
            $display("sorted_key_table_top regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_cell.sv
hdl/skt_ctrl.sv
hdl/sorted_key_table_top.sv
sim/tb_sorted_key_table_top.sv
